@@ sv/bcsd_pkg.sv @@
// shared types, constants and register codes for the charge state detector
package bcsd_pkg;

   localparam int MV_W    = 15;
   localparam int TIME_W  = 48;
   localparam int SLOPE_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef logic [MV_W-1:0]        mv_type;
   typedef logic [TIME_W-1:0]      time_type;
   typedef logic signed [SLOPE_W-1:0] slope_type;
   typedef logic [CSR_IDX_W-1:0]   csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // reported charge state codes
   typedef enum logic [1:0] {
      CS_IDLE        = 2'd0,
      CS_CHARGING    = 2'd1,
      CS_FULL        = 2'd2,
      CS_DISCHARGING = 2'd3
   } charge_state_type;

   // register indexes
   localparam csr_idx_type CSR_INTERVAL    = 3'd0;
   localparam csr_idx_type CSR_RISING      = 3'd1;
   localparam csr_idx_type CSR_FALLING     = 3'd2;
   localparam csr_idx_type CSR_LIKELY_FULL = 3'd3;
   localparam csr_idx_type CSR_HOLD        = 3'd4;
   localparam csr_idx_type CSR_FULL        = 3'd5;
   localparam csr_idx_type CSR_PEAK_DROP   = 3'd6;

   // register reset values
   localparam logic [15:0]        RST_INTERVAL    = 16'd1000;
   localparam logic signed [10:0] RST_RISING      = 11'sd5;
   localparam logic signed [10:0] RST_FALLING     = -11'sd5;
   localparam mv_type             RST_LIKELY_FULL = 15'd4100;
   localparam logic [23:0]        RST_HOLD        = 24'd60000;
   localparam mv_type             RST_FULL        = 15'd4150;
   localparam mv_type             RST_PEAK_DROP   = 15'd50;

   // fixed thresholds
   localparam logic signed [16:0] JUMP_LIMIT_MV = 17'sd30;
   localparam mv_type             FLAT_SLOPE_MV = 15'd2;

   // commands from the sequencer to the sample ring
   typedef struct packed {
      logic push;
      logic scan_start;
   } ring_cmd_type;

   // status from the sample ring
   typedef struct packed {
      logic   scan_done;
      mv_type newest;
      mv_type oldest;
      mv_type median;
   } ring_stat_type;

endpackage

@@ sv/bcsd_if.sv @@
// handshake channel interfaces: sample request, state response, register write
interface bcsd_req_if import bcsd_pkg::*;;
   logic     valid;
   logic     ready;
   mv_type   battery_mv;
   logic     reading_valid;
   time_type time_ms;

   modport source (output valid, output battery_mv, output reading_valid, output time_ms,
                   input ready);
   modport sink (input valid, input battery_mv, input reading_valid, input time_ms,
                 output ready);
endinterface

interface bcsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] charge_state;
   logic       charging;
   logic       charging_changed;

   modport source (output valid, output charge_state, output charging,
                   output charging_changed, input ready);
   modport sink (input valid, input charge_state, input charging,
                 input charging_changed, output ready);
endinterface

interface bcsd_csr_if import bcsd_pkg::*;;
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/battery_charge_state_detector_top.sv @@
// an invalid reading goes from accept straight to the response step; a valid one first
// passes the interval and jump check, and a kept sample that fills or lands on a full ring
// then runs scan, divide and decide; the response step waits for a free output register
// one word at a time: a new sample is accepted only in idle, after the response step;
// a new sample is taken while an earlier result still waits in the output register
// reset is synchronous, active high: registers to defaults, state idle, ring empty
module battery_charge_state_detector_top import bcsd_pkg::*; #(
   parameter int RING_SIZE = 8
) (
   input logic         clock,
   input logic         reset,
   bcsd_req_if.sink    req_bus,
   bcsd_rsp_if.source  rsp_bus,
   bcsd_csr_if.sink    csr_bus
);

   localparam int CNTW = $clog2(RING_SIZE + 1);
   localparam logic [CNTW-1:0] FULL_CNT = CNTW'(RING_SIZE);
   localparam logic [CNTW-1:0] PRE_FULL = CNTW'(RING_SIZE - 1);

   typedef enum logic [4:0] {
      SQ_IDLE  = 5'b00001,
      SQ_CHECK = 5'b00010,
      SQ_SCAN  = 5'b00100,
      SQ_DIV   = 5'b01000,
      SQ_DONE  = 5'b10000
   } seq_state_type;

   // configuration registers
   logic [15:0]        interval_ff;
   logic signed [10:0] rising_ff;
   logic signed [10:0] falling_ff;
   mv_type             likely_ff;
   logic [23:0]        hold_ff;
   mv_type             full_ff;
   mv_type             drop_ff;

   // sequencer and tracking state
   seq_state_type    seq_ff;
   seq_state_type    seq_in;
   mv_type           mv_ff;
   time_type         now_ff;
   logic [CNTW-1:0]  count_ff;
   time_type         last_ff;
   time_type         high_ff;
   mv_type           peak_ff;
   charge_state_type cs_ff;
   charge_state_type cs_in;
   logic             last_chg_ff;
   logic             hold_ok_ff;
   logic             neg_ff;

   // response register
   logic             rsp_valid_ff;
   logic [1:0]       rsp_state_ff;
   logic             rsp_chg_ff;
   logic             rsp_changed_ff;

   ring_cmd_type     ring_cmd;
   ring_stat_type    ring_stat;
   logic             div_done;
   mv_type           quot;
   logic             req_fire;

   assign req_bus.ready = seq_ff == SQ_IDLE;
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= RST_INTERVAL;
         rising_ff   <= RST_RISING;
         falling_ff  <= RST_FALLING;
         likely_ff   <= RST_LIKELY_FULL;
         hold_ff     <= RST_HOLD;
         full_ff     <= RST_FULL;
         drop_ff     <= RST_PEAK_DROP;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_INTERVAL:    interval_ff <= csr_bus.data[15:0];
            CSR_RISING:      rising_ff   <= csr_bus.data[10:0];
            CSR_FALLING:     falling_ff  <= csr_bus.data[10:0];
            CSR_LIKELY_FULL: likely_ff   <= csr_bus.data[MV_W-1:0];
            CSR_HOLD:        hold_ff     <= csr_bus.data;
            CSR_FULL:        full_ff     <= csr_bus.data[MV_W-1:0];
            CSR_PEAK_DROP:   drop_ff     <= csr_bus.data[MV_W-1:0];
            default: ;
         endcase
      end
   end

   // shared time compare: interval check, then hold check
   time_type          tref;
   logic [23:0]       tlimit;
   logic [TIME_W:0]   tdiff;
   logic              t_ge;

   always_comb begin
      if (seq_ff == SQ_CHECK) begin
         tref   = last_ff;
         tlimit = {8'd0, interval_ff};
      end else begin
         tref   = high_ff;
         tlimit = hold_ff;
      end
      tdiff = {1'b0, now_ff} - {1'b0, tref};
      t_ge  = !tdiff[TIME_W] && (tdiff[TIME_W-1:0] >= {24'd0, tlimit});
   end

   // sample acceptance
   logic               skip;
   logic signed [16:0] jump;
   logic               jump_hit;
   logic               take;

   always_comb begin
      skip     = (last_ff != '0) && !t_ge;
      jump     = $signed({2'b00, mv_ff}) - $signed({2'b00, ring_stat.newest});
      jump_hit = (count_ff != '0) && ((jump > JUMP_LIMIT_MV) || (jump < -JUMP_LIMIT_MV));
      take     = (seq_ff == SQ_CHECK) && !skip && !jump_hit;
   end

   assign ring_cmd.push       = take;
   assign ring_cmd.scan_start = take && (count_ff >= PRE_FULL);

   bcsd_ring #(
      .RING_SIZE(RING_SIZE)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .push_mv (mv_ff),
      .stat    (ring_stat)
   );

   // span between newest and oldest, split into sign and magnitude
   logic signed [SLOPE_W-1:0] span;
   logic [SLOPE_W-1:0]        span_mag;
   logic                      div_start;

   assign span      = $signed({1'b0, ring_stat.newest}) - $signed({1'b0, ring_stat.oldest});
   assign span_mag  = span[SLOPE_W-1] ? SLOPE_W'(-span) : span;
   assign div_start = (seq_ff == SQ_SCAN) && ring_stat.scan_done;

   bcsd_div #(
      .RING_SIZE(RING_SIZE)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (span_mag[MV_W-1:0]),
      .done     (div_done),
      .quotient (quot)
   );

   // charge state decision
   slope_type          slope;
   logic               flat;
   logic               rise;
   logic               fall;
   logic signed [16:0] drop_level;
   logic               drop_hit;
   logic               med_full;

   always_comb begin
      slope      = neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      flat       = quot <= FLAT_SLOPE_MV;
      rise       = slope > SLOPE_W'(rising_ff);
      fall       = slope < SLOPE_W'(falling_ff);
      med_full   = ring_stat.median >= full_ff;
      drop_level = $signed({2'b00, peak_ff}) - $signed({2'b00, drop_ff});
      drop_hit   = $signed({2'b00, ring_stat.median}) <= drop_level;
      cs_in      = cs_ff;
      case (cs_ff)
         CS_IDLE: begin
            if (rise) cs_in = CS_CHARGING;
            else if (fall) cs_in = CS_DISCHARGING;
            else if ((high_ff != '0) && hold_ok_ff) cs_in = CS_FULL;
         end
         CS_CHARGING: begin
            if (med_full && flat) cs_in = CS_FULL;
            else if (flat) cs_in = CS_IDLE;
            else if (fall) cs_in = CS_DISCHARGING;
         end
         CS_FULL: begin
            if (drop_hit) cs_in = CS_DISCHARGING;
         end
         CS_DISCHARGING: begin
            if (rise) cs_in = CS_CHARGING;
            else if (flat) cs_in = CS_IDLE;
         end
         default: cs_in = CS_IDLE;
      endcase
   end

   // sequencer next state
   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SQ_IDLE: begin
            if (req_fire) seq_in = req_bus.reading_valid ? SQ_CHECK : SQ_DONE;
         end
         SQ_CHECK: seq_in = ring_cmd.scan_start ? SQ_SCAN : SQ_DONE;
         SQ_SCAN:  if (ring_stat.scan_done) seq_in = SQ_DIV;
         SQ_DIV:   if (div_done) seq_in = SQ_DONE;
         SQ_DONE:  if (rsp_free) seq_in = SQ_IDLE;
         default:  seq_in = SQ_IDLE;
      endcase
   end

   // captured sample word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mv_ff  <= req_bus.battery_mv;
         now_ff <= req_bus.time_ms;
      end
   end

   // control and tracking state
   logic chg_now;
   assign chg_now = (cs_ff == CS_CHARGING) || (cs_ff == CS_FULL);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff         <= SQ_IDLE;
         count_ff       <= '0;
         last_ff        <= '0;
         high_ff        <= '0;
         peak_ff        <= '0;
         cs_ff          <= CS_IDLE;
         last_chg_ff    <= 1'b0;
         hold_ok_ff     <= 1'b0;
         neg_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_state_ff   <= CS_IDLE;
         rsp_chg_ff     <= 1'b0;
         rsp_changed_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         // interval restarts on both a kept and a dropped sample
         if ((seq_ff == SQ_CHECK) && !skip) begin
            last_ff <= now_ff;
         end
         if (take && (count_ff != FULL_CNT)) begin
            count_ff <= count_ff + CNTW'(1);
         end
         // peak and sustained-high start once the median is known
         if (div_start) begin
            neg_ff <= span[SLOPE_W-1];
            if (ring_stat.median > peak_ff) begin
               peak_ff <= ring_stat.median;
            end
            if (ring_stat.median >= likely_ff) begin
               if (high_ff == '0) high_ff <= now_ff;
            end else begin
               high_ff <= '0;
            end
         end
         if (seq_ff == SQ_DIV) begin
            hold_ok_ff <= t_ge;
            if (div_done) cs_ff <= cs_in;
         end
         // response register
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((seq_ff == SQ_DONE) && rsp_free) begin
            rsp_valid_ff   <= 1'b1;
            rsp_state_ff   <= cs_ff;
            rsp_chg_ff     <= chg_now;
            rsp_changed_ff <= chg_now != last_chg_ff;
            last_chg_ff    <= chg_now;
         end
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.charge_state     = rsp_state_ff;
   assign rsp_bus.charging         = rsp_chg_ff;
   assign rsp_bus.charging_changed = rsp_changed_ff;

endmodule

@@ sv/bcsd_ring.sv @@
// sample ring as a shift line, with a rank-count median scan over one candidate a cycle
module bcsd_ring import bcsd_pkg::*; #(
   parameter int RING_SIZE = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  ring_cmd_type  cmd,
   input  mv_type        push_mv,
   output ring_stat_type stat
);

   localparam int IW = $clog2(RING_SIZE);
   localparam logic [IW-1:0] LAST_IDX = IW'(RING_SIZE - 1);
   localparam logic [IW-1:0] MED_RANK = IW'(RING_SIZE / 2);

   mv_type        taps_ff [RING_SIZE];
   mv_type        median_ff;
   logic [IW-1:0] idx_ff;
   logic          scan_ff;
   logic          done_ff;
   mv_type        cand;
   logic [IW-1:0] rank;

   // shift line, newest at tap zero
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         taps_ff[0] <= push_mv;
         for (int i = 1; i < RING_SIZE; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
      end
   end

   // rank of the candidate, ties broken by tap position
   always_comb begin
      cand = taps_ff[idx_ff];
      rank = '0;
      for (int j = 0; j < RING_SIZE; j++) begin
         if ((taps_ff[j] < cand) || ((taps_ff[j] == cand) && (IW'(j) < idx_ff))) begin
            rank = rank + IW'(1);
         end
      end
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.scan_start) begin
            scan_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (scan_ff) begin
            if (idx_ff == LAST_IDX) begin
               scan_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff + IW'(1);
            end
         end
      end
   end

   // capture the upper median
   always_ff @(posedge clock) begin
      if (scan_ff && (rank == MED_RANK)) begin
         median_ff <= cand;
      end
   end

   assign stat.scan_done = done_ff;
   assign stat.newest    = taps_ff[0];
   assign stat.oldest    = taps_ff[RING_SIZE-1];
   assign stat.median    = median_ff;

endmodule

@@ sv/bcsd_div.sv @@
// span divider: reciprocal multiply by the fixed ring span, product then quotient registered
module bcsd_div import bcsd_pkg::*; #(
   parameter int RING_SIZE = 8
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   start,
   input  mv_type dividend,
   output logic   done,
   output mv_type quotient
);

   // floor(x / d) == (x * ceil(2^s / d)) >> s for every x below 2^MV_W
   localparam int DIVISOR = RING_SIZE - 1;
   localparam int SHIFT   = MV_W + $clog2(DIVISOR);
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = MV_W + RECIP_W;
   localparam longint RECIP_VAL =
      ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   logic [PROD_W-1:0] prod_ff;
   mv_type            quot_ff;
   logic              mul_ff;
   logic              done_ff;

   // product, then quotient taken from the upper bits
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= {{RECIP_W{1'b0}}, dividend} * {{MV_W{1'b0}}, RECIP};
      end
      if (mul_ff) begin
         quot_ff <= prod_ff[SHIFT +: MV_W];
      end
   end

   // two-stage done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= start;
         done_ff <= mul_ff;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

@@ sv/bcsd_checker.sv @@
// port-level checks for the charge state detector, bound to the top level
module bcsd_checker import bcsd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_state,
   input logic       rsp_charging,
   input logic       rsp_changed
);

   // held response word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_state)
         && $stable(rsp_charging) && $stable(rsp_changed))
      else $error("response word changed while stalled");

   // an accepted sample leaves the block busy in the cycle after
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a sample is still in work");

   // charging flag follows the reported state
   a_chg_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_charging == ((rsp_state == CS_CHARGING) || (rsp_state == CS_FULL)))
      else $error("charging flag disagrees with the state");

   // after reset the block is empty and waiting
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind battery_charge_state_detector_top bcsd_checker u_bcsd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_state    (rsp_bus.charge_state),
   .rsp_charging (rsp_bus.charging),
   .rsp_changed  (rsp_bus.charging_changed)
);

@@ tb/tb_top.sv @@
// testbench for the battery charge state detector: predicted against observed state reports
`timescale 1ns / 100ps

module tb_top import bcsd_pkg::*;;

   localparam int RING          = 8;
   localparam int MV_MAX        = (1 << MV_W) - 1;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_PCT      = 18;
   localparam int HOLD_OFF      = 400;
   localparam csr_idx_type CSR_UNUSED = 3'd7;

   // one sample word and one state report word
   typedef struct packed {
      mv_type   battery_mv;
      logic     reading_valid;
      time_type time_ms;
   } tick_type;

   typedef struct packed {
      charge_state_type charge_state;
      logic             charging;
      logic             charging_changed;
   } report_type;

   logic clock;
   logic reset;

   bcsd_req_if req_bus ();
   bcsd_rsp_if rsp_bus ();
   bcsd_csr_if csr_bus ();

   battery_charge_state_detector_top #(.RING_SIZE(RING)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // shadow copy of the thresholds
   int cfg_interval;
   int cfg_rising;
   int cfg_falling;
   int cfg_likely_full;
   int cfg_hold;
   int cfg_full;
   int cfg_peak_drop;

   // shadow copy of the detector state
   int               ring_mv [RING];
   int               wr_slot;
   int               fill_count;
   time_type         last_take_ms;
   time_type         high_start_ms;
   int               peak_mid_mv;
   charge_state_type cur_state;
   logic             prev_charging;

   tick_type   sample_backlog [$];
   report_type expected_reports [$];
   tick_type   in_flight;

   int err_cnt    = 0;
   int cycle_cnt  = 0;
   int report_cnt = 0;
   int stall_left = 0;
   bit stall_done = 1'b0;

   // stimulus cursor: newest stored voltage and its time
   time_type gen_ms;
   int       gen_mv;
   int       gen_extra;

   function automatic void restore_defaults();
      cfg_interval    = int'(RST_INTERVAL);
      cfg_rising      = int'(RST_RISING);
      cfg_falling     = int'(RST_FALLING);
      cfg_likely_full = int'(RST_LIKELY_FULL);
      cfg_hold        = int'(RST_HOLD);
      cfg_full        = int'(RST_FULL);
      cfg_peak_drop   = int'(RST_PEAK_DROP);
      for (int i = 0; i < RING; i++) ring_mv[i] = 0;
      wr_slot       = 0;
      fill_count    = 0;
      last_take_ms  = '0;
      high_start_ms = '0;
      peak_mid_mv   = 0;
      cur_state     = CS_IDLE;
      prev_charging = 1'b0;
   endfunction

   function automatic void apply_register(csr_idx_type idx, csr_data_type d);
      case (idx)
         CSR_INTERVAL:    cfg_interval    = int'(d[15:0]);
         CSR_RISING:      cfg_rising      = int'($signed(d[10:0]));
         CSR_FALLING:     cfg_falling     = int'($signed(d[10:0]));
         CSR_LIKELY_FULL: cfg_likely_full = int'(d[14:0]);
         CSR_HOLD:        cfg_hold        = int'(d[23:0]);
         CSR_FULL:        cfg_full        = int'(d[14:0]);
         CSR_PEAK_DROP:   cfg_peak_drop   = int'(d[14:0]);
         default: ;
      endcase
   endfunction

   // upper median of the ring
   function automatic int ring_median();
      int s [RING];
      int key;
      int j;
      for (int i = 0; i < RING; i++) s[i] = ring_mv[i];
      for (int i = 1; i < RING; i++) begin
         key = s[i];
         j = i - 1;
         while (j >= 0 && s[j] > key) begin
            s[j+1] = s[j];
            j--;
         end
         s[j+1] = key;
      end
      return s[RING/2];
   endfunction

   // four-state machine, run on every stored sample once the ring is full
   function automatic void step_state(int mid, time_type now);
      int     slope;
      bit     flat;
      longint age;
      slope = (ring_mv[(wr_slot + RING - 1) % RING] - ring_mv[wr_slot]) / (RING - 1);
      flat  = (slope <= int'(FLAT_SLOPE_MV)) && (slope >= -int'(FLAT_SLOPE_MV));
      if (mid >= cfg_likely_full) begin
         if (high_start_ms == '0) high_start_ms = now;
      end else begin
         high_start_ms = '0;
      end
      age = longint'({16'd0, now}) - longint'({16'd0, high_start_ms});
      case (cur_state)
         CS_IDLE: begin
            if (slope > cfg_rising) cur_state = CS_CHARGING;
            else if (slope < cfg_falling) cur_state = CS_DISCHARGING;
            else if (high_start_ms != '0 && age >= cfg_hold) cur_state = CS_FULL;
         end
         CS_CHARGING: begin
            if (mid >= cfg_full && flat) cur_state = CS_FULL;
            else if (flat) cur_state = CS_IDLE;
            else if (slope < cfg_falling) cur_state = CS_DISCHARGING;
         end
         CS_FULL: begin
            if (mid <= peak_mid_mv - cfg_peak_drop) cur_state = CS_DISCHARGING;
         end
         default: begin
            if (slope > cfg_rising) cur_state = CS_CHARGING;
            else if (flat) cur_state = CS_IDLE;
         end
      endcase
   endfunction

   // interval gate, jump filter, ring store
   function automatic void take_sample(int mv, time_type now);
      longint since;
      int     newest;
      int     mid;
      since = longint'({16'd0, now}) - longint'({16'd0, last_take_ms});
      if (last_take_ms != '0 && since < cfg_interval) return;
      newest = ring_mv[(wr_slot + RING - 1) % RING];
      if (fill_count > 0 && (mv - newest > int'(JUMP_LIMIT_MV) ||
                             newest - mv > int'(JUMP_LIMIT_MV))) begin
         last_take_ms = now;
         return;
      end
      ring_mv[wr_slot] = mv;
      wr_slot = (wr_slot + 1) % RING;
      if (fill_count < RING) fill_count++;
      last_take_ms = now;
      if (fill_count >= RING) begin
         mid = ring_median();
         if (mid > peak_mid_mv) peak_mid_mv = mid;
         step_state(mid, now);
      end
   endfunction

   function automatic report_type predict_report(tick_type t);
      report_type r;
      logic       chg;
      if (t.reading_valid) take_sample(int'(t.battery_mv), t.time_ms);
      chg = (cur_state == CS_CHARGING || cur_state == CS_FULL);
      r.charge_state     = cur_state;
      r.charging         = chg;
      r.charging_changed = (chg != prev_charging);
      prev_charging = chg;
      return r;
   endfunction

   function automatic bit take_break();
      return ((cycle_cnt % 3000) >= 700) && (int'($urandom_range(99)) < IDLE_PCT);
   endfunction

   function automatic int clamp_mv(int v);
      return (v < 0) ? 0 : ((v > MV_MAX) ? MV_MAX : v);
   endfunction

   function automatic void queue_tick(int mv, bit ok, time_type ms);
      tick_type t;
      t.battery_mv    = mv_type'(mv);
      t.reading_valid = ok;
      t.time_ms       = ms;
      sample_backlog.push_back(t);
   endfunction

   // time zero, invalid, jump, early, backwards, then charge, full and discharge
   function automatic void queue_directed();
      time_type ms;
      int       mv;
      queue_tick(4000, 1'b1, '0);
      queue_tick(4001, 1'b1, 48'd5);
      queue_tick(MV_MAX, 1'b0, 48'd10);
      queue_tick(0, 1'b1, 48'd1500);
      queue_tick(4010, 1'b1, 48'd2000);
      queue_tick(4010, 1'b1, 48'd2600);
      queue_tick(4005, 1'b1, 48'd1000);
      queue_tick(0, 1'b0, '1);
      ms = 48'd3600;
      mv = 4010;
      for (int k = 0; k < 7; k++) begin
         mv += 28;
         queue_tick(mv, 1'b1, ms);
         ms += 48'd1000;
      end
      for (int k = 0; k < 7; k++) begin
         queue_tick(mv, 1'b1, ms);
         ms += 48'd1000;
      end
      for (int k = 0; k < 5; k++) begin
         mv -= 25;
         queue_tick(mv, 1'b1, ms);
         ms += 48'd1000;
      end
      gen_ms = ms - 48'd1000;
      gen_mv = mv;
   endfunction

   // drifting voltage segments with a sprinkle of rejected and skipped samples
   function automatic void queue_random(int n, bit steer);
      int left;
      int seg;
      int lo;
      int hi;
      int roll;
      int mv;
      left = n;
      while (left > 0) begin
         seg = int'($urandom_range(8, 30));
         case ($urandom_range(3))
            0: begin lo = 4; hi = 22; end
            1: begin lo = -2; hi = 2; end
            2: begin lo = -22; hi = -4; end
            default: begin lo = -30; hi = 30; end
         endcase
         // keep the walk near the thresholds
         if (steer && gen_mv > cfg_full + 200) begin
            lo = -22; hi = -4;
         end else if (steer && gen_mv < cfg_likely_full - 300) begin
            lo = 4; hi = 22;
         end
         while (seg > 0 && left > 0) begin
            roll = int'($urandom_range(99));
            if (roll < 6) begin
               // failed reading, any voltage
               queue_tick(int'($urandom_range(MV_MAX)), 1'b0,
                          gen_ms + time_type'($urandom_range(2000)));
            end else if (roll < 11 && cfg_interval > 0) begin
               // too soon after the last sample
               queue_tick(gen_mv, 1'b1,
                          gen_ms + time_type'($urandom_range(cfg_interval - 1)));
            end else if (roll < 15) begin
               // implausible jump, dropped but restarts the interval
               if ($urandom_range(1)) mv = int'($urandom_range(MV_MAX));
               else mv = gen_mv + 31 + int'($urandom_range(500));
               if (mv > MV_MAX) mv = gen_mv - 31 - int'($urandom_range(500));
               if (mv - gen_mv <= int'(JUMP_LIMIT_MV) && gen_mv - mv <= int'(JUMP_LIMIT_MV))
                  mv = (gen_mv >= 100) ? gen_mv - 100 : gen_mv + 100;
               gen_ms = gen_ms + time_type'(cfg_interval) + time_type'($urandom_range(gen_extra));
               queue_tick(mv, 1'b1, gen_ms);
            end else if (roll < 17 && gen_ms > 48'd5000) begin
               // clock going backwards
               queue_tick(gen_mv, 1'b1, gen_ms - time_type'($urandom_range(1, 5000)));
            end else begin
               gen_mv = clamp_mv(gen_mv + lo + int'($urandom_range(hi - lo)));
               gen_ms = gen_ms + time_type'(cfg_interval) + time_type'($urandom_range(gen_extra));
               queue_tick(gen_mv, 1'b1, gen_ms);
            end
            seg--;
            left--;
         end
      end
   endfunction

   task automatic write_register(csr_idx_type idx, int value);
      csr_data_type keep;
      csr_data_type word;
      case (idx)
         CSR_INTERVAL:             keep = 24'h00FFFF;
         CSR_RISING, CSR_FALLING:  keep = 24'h0007FF;
         CSR_HOLD:                 keep = 24'hFFFFFF;
         default:                  keep = 24'h007FFF;
      endcase
      // unused upper bits carry junk
      word = (csr_data_type'(value) & keep) | (csr_data_type'($urandom) & ~keep);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= word;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      apply_register(idx, word);
   endtask

   task automatic write_set(int iv, int rise, int fall, int lf, int hold, int fu, int pd);
      write_register(CSR_INTERVAL, iv);
      write_register(CSR_RISING, rise);
      write_register(CSR_FALLING, fall);
      write_register(CSR_LIKELY_FULL, lf);
      write_register(CSR_HOLD, hold);
      write_register(CSR_FULL, fu);
      write_register(CSR_PEAK_DROP, pd);
   endtask

   task automatic wait_drained();
      while (sample_backlog.size() != 0 || req_bus.valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

   always @(posedge clock) cycle_cnt <= cycle_cnt + 1;

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.battery_mv    <= '0;
         req_bus.reading_valid <= 1'b0;
         req_bus.time_ms       <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_reports.push_back(predict_report(in_flight));
         if (!req_bus.valid || req_bus.ready) begin
            if (sample_backlog.size() != 0 && !take_break()) begin
               in_flight = sample_backlog.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.battery_mv    <= in_flight.battery_mv;
               req_bus.reading_valid <= in_flight.reading_valid;
               req_bus.time_ms       <= in_flight.time_ms;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // report monitor with one long hold-off
   always @(posedge clock) begin : watch_reports
      report_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            report_cnt++;
            if (expected_reports.size() == 0) begin
               err_cnt++;
               $error("unexpected report word: charge_state %0d", rsp_bus.charge_state);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_bus.charge_state !== want.charge_state) begin
                  err_cnt++;
                  $error("charge_state: expected %0d, got %0d",
                         want.charge_state, rsp_bus.charge_state);
               end
               if (rsp_bus.charging !== want.charging) begin
                  err_cnt++;
                  $error("charging: expected %0d, got %0d", want.charging, rsp_bus.charging);
               end
               if (rsp_bus.charging_changed !== want.charging_changed) begin
                  err_cnt++;
                  $error("charging_changed: expected %0d, got %0d",
                         want.charging_changed, rsp_bus.charging_changed);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
         end else if (!stall_done && report_cnt >= 200) begin
            stall_left = HOLD_OFF;
            stall_done = 1'b1;
         end
         rsp_bus.ready <= (stall_left == 0) && !take_break();
      end
   end

   // reset, register settings and stimulus phases
   initial begin : run
      int lf;
      reset         = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      restore_defaults();
      gen_ms    = '0;
      gen_mv    = 4000;
      gen_extra = 500;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds
      queue_directed();
      wait_drained();

      // low extremes
      write_set(0, 1000, -1000, 0, 0, 0, 0);
      gen_extra = 50;
      queue_random(50, 1'b0);
      wait_drained();

      // high extremes, late in time, plus an unmapped index
      write_set(65535, -1000, 1000, MV_MAX, 16777215, MV_MAX, MV_MAX);
      write_register(CSR_UNUSED, int'($urandom));
      gen_ms    = {1'b1, 15'($urandom), 32'($urandom)};
      gen_extra = 3000;
      queue_random(50, 1'b0);
      wait_drained();

      // thresholds placed around the present voltage
      for (int p = 0; p < 4; p++) begin
         lf = clamp_mv(gen_mv - 100 + int'($urandom_range(250)));
         write_set(int'($urandom_range(3000)), int'($urandom_range(1, 20)),
                   -int'($urandom_range(1, 20)), lf, int'($urandom_range(120000)),
                   clamp_mv(lf + int'($urandom_range(80))), int'($urandom_range(5, 100)));
         gen_extra = int'($urandom_range(12000));
         queue_random(130, 1'b1);
         wait_drained();
      end

      if (err_cnt == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule

@@ battery_charge_state_detector_top.f @@
sv/bcsd_pkg.sv
sv/bcsd_if.sv
sv/bcsd_ring.sv
sv/bcsd_div.sv
sv/battery_charge_state_detector_top.sv
sv/bcsd_checker.sv
tb/tb_top.sv
